[hw/rtl/itra_pkg.sv]
`default_nettype none
package itra_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W      = $clog2(VALUE_WIDTH);
  localparam int DIGIT_W     = 6;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int PC_W        = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RADIX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NEG_RADIX = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_DSTART,
    OP_DSTORE,
    OP_MINUS,
    OP_RDADDR,
    OP_EMITD,
    OP_ZERO,
    OP_ERR
  } itra_op_t;

  // Jump condition selected by a control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_BAD,
    C_ZERO,
    C_DIV_BUSY,
    C_MORE,
    C_NO_SIGN,
    C_CNT_NZ
  } itra_cond_t;

  typedef struct packed {
    itra_op_t              op;
    itra_cond_t            cond;
    logic [PC_W-1:0]       target;
  } itra_cw_t;

  typedef struct packed {
    logic in_fire;
    logic bad;
    logic mag_zero;
    logic div_busy;
    logic more;
    logic sign;
    logic cnt_nz;
    logic stall;
  } itra_flags_t;

  localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK  = 4'd1;
  localparam logic [PC_W-1:0] STEP_TESTZ  = 4'd2;
  localparam logic [PC_W-1:0] STEP_DSTART = 4'd3;
  localparam logic [PC_W-1:0] STEP_DWAIT  = 4'd4;
  localparam logic [PC_W-1:0] STEP_DSTORE = 4'd5;
  localparam logic [PC_W-1:0] STEP_SIGNT  = 4'd6;
  localparam logic [PC_W-1:0] STEP_MINUS  = 4'd7;
  localparam logic [PC_W-1:0] STEP_RDADDR = 4'd8;
  localparam logic [PC_W-1:0] STEP_EMITD  = 4'd9;
  localparam logic [PC_W-1:0] STEP_END    = 4'd10;
  localparam logic [PC_W-1:0] STEP_ZERO   = 4'd11;
  localparam logic [PC_W-1:0] STEP_ERR    = 4'd12;

  // Control store. A true condition jumps to the target, otherwise the
  // step counter advances by one.
  function automatic itra_cw_t ucode(input logic [PC_W-1:0] pc);
    itra_cw_t cw;
    case (pc)
      STEP_WAIT:   cw = '{OP_ACCEPT, C_NO_IN,    STEP_WAIT};
      STEP_CHECK:  cw = '{OP_LOAD,   C_BAD,      STEP_ERR};
      STEP_TESTZ:  cw = '{OP_NOP,    C_ZERO,     STEP_ZERO};
      STEP_DSTART: cw = '{OP_DSTART, C_NEVER,    STEP_WAIT};
      STEP_DWAIT:  cw = '{OP_NOP,    C_DIV_BUSY, STEP_DWAIT};
      STEP_DSTORE: cw = '{OP_DSTORE, C_MORE,     STEP_DSTART};
      STEP_SIGNT:  cw = '{OP_NOP,    C_NO_SIGN,  STEP_RDADDR};
      STEP_MINUS:  cw = '{OP_MINUS,  C_NEVER,    STEP_WAIT};
      STEP_RDADDR: cw = '{OP_RDADDR, C_NEVER,    STEP_WAIT};
      STEP_EMITD:  cw = '{OP_EMITD,  C_CNT_NZ,   STEP_RDADDR};
      STEP_END:    cw = '{OP_NOP,    C_ALWAYS,   STEP_WAIT};
      STEP_ZERO:   cw = '{OP_ZERO,   C_ALWAYS,   STEP_SIGNT};
      STEP_ERR:    cw = '{OP_ERR,    C_ALWAYS,   STEP_WAIT};
      default:     cw = '{OP_NOP,    C_ALWAYS,   STEP_WAIT};
    endcase
    return cw;
  endfunction

  // Digit value to its ASCII character, 0-9 then A-Z.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] dd;
    dd = (d >= RADIX_MAX) ? d - RADIX_MAX : d;
    if (dd < RADIX_DEC) begin
      return CHAR_ZERO + {2'b00, dd};
    end
    return CHAR_A + {2'b00, dd} - {2'b00, RADIX_DEC};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/itra_div.sv]
`default_nettype none
module itra_div
  import itra_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [RADIX_W-1:0]     divisor,
  output logic                        busy,
  output logic [VALUE_WIDTH-1:0]      quot,
  output logic [DIGIT_W-1:0]          rem
);

  // Restoring division, one quotient bit per cycle.
  logic [RADIX_W-1:0] div_q;
  logic [CNT_W-1:0]   iter;
  logic [DIGIT_W:0]   trial;
  logic               ge;

  assign trial = {rem, quot[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= CNT_W'(VALUE_WIDTH);
    end else if (busy) begin
      iter <= iter - 1'b1;
      if (iter == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= dividend;
      rem   <= '0;
      div_q <= divisor;
    end else if (busy) begin
      quot <= {quot[VALUE_WIDTH-2:0], ge};
      rem  <= ge ? DIGIT_W'(trial - {1'b0, div_q}) : trial[DIGIT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/itra_seq.sv]
`default_nettype none
module itra_seq
  import itra_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire itra_flags_t flags,
  output itra_cw_t         cw
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign cw = ucode(pc);

  always_comb begin
    case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !flags.in_fire;
      C_BAD:      take = flags.bad;
      C_ZERO:     take = flags.mag_zero;
      C_DIV_BUSY: take = flags.div_busy;
      C_MORE:     take = flags.more;
      C_NO_SIGN:  take = !flags.sign;
      C_CNT_NZ:   take = flags.cnt_nz;
      default:    take = 1'b0;
    endcase
    if (flags.stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/integer_to_radix_ascii.sv]
`default_nettype none
// A conversion checks its input, then runs the bit-serial divider once per digit and stores
// each remainder; it then loads a minus sign, if any, and the digits, most significant first;
// zero skips the divider, and an error loads a single error result.
// Throughput: one conversion at a time; the next input is taken once the last character has
// been loaded into the output register. Each digit of a nonzero value costs one divider pass.
// Reset: synchronous, active high; it returns the step counter to the wait step and empties
// the output register. The digit store is not cleared.
module integer_to_radix_ascii
  import itra_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  input  wire logic [RADIX_W-1:0]            radix,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [CHAR_W-1:0]                  character,
  output logic                               last,
  output logic [STATUS_W-1:0]                status
);

  // The sequencer steps through a small control store; each control word
  // selects one datapath operation and one jump condition.
  itra_cw_t    cw;
  itra_flags_t flags;

  logic [VALUE_WIDTH-1:0] value_q;
  logic [RADIX_W-1:0]     radix_q;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [CNT_W-1:0]       count;
  logic                   sign_pending;
  logic [DIGIT_W-1:0]     rdata;

  // Digit store: least significant digit at address zero.
  logic [DIGIT_W-1:0]     digit_store [VALUE_WIDTH];

  logic                   div_start;
  logic                   div_busy;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_rem;

  logic                   in_fire;
  logic                   radix_bad;
  logic                   neg_bad;
  logic                   emit;
  logic                   slot_free;
  logic                   stall;
  logic                   load_out;
  logic [VALUE_WIDTH-1:0] abs_value;
  logic [CNT_W-1:0]       count_dec;

  assign in_ready  = (cw.op == OP_ACCEPT);
  assign in_fire   = in_valid && in_ready;

  // The radix check takes precedence over the sign check.
  assign radix_bad = (radix_q < RADIX_MIN) || (radix_q > RADIX_MAX);
  assign neg_bad   = value_q[VALUE_WIDTH-1] && (radix_q != RADIX_DEC);

  // The magnitude is formed unsigned, so the most negative value converts.
  assign abs_value = value_q[VALUE_WIDTH-1] ?
                     (~value_q) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : value_q;

  // Operations that load a character wait while the output register is full and out_ready is low.
  assign emit      = (cw.op == OP_MINUS) || (cw.op == OP_EMITD) || (cw.op == OP_ERR);
  assign slot_free = !out_valid || out_ready;
  assign stall     = emit && !slot_free;
  assign load_out  = emit && slot_free;
  assign div_start = (cw.op == OP_DSTART);
  assign count_dec = count - 1'b1;

  always_comb begin
    flags.in_fire  = in_fire;
    flags.bad      = radix_bad || neg_bad;
    flags.mag_zero = (magnitude == '0);
    flags.div_busy = div_busy;
    flags.more     = (div_quot != '0) && (count < CNT_W'(VALUE_WIDTH - 1));
    flags.sign     = sign_pending;
    flags.cnt_nz   = (count != '0);
    flags.stall    = stall;
  end

  itra_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  itra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (magnitude),
    .divisor  (radix_q),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Conversion registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude    <= '0;
      count        <= '0;
      sign_pending <= 1'b0;
    end else begin
      case (cw.op)
        OP_LOAD: begin
          magnitude    <= abs_value;
          count        <= '0;
          sign_pending <= value_q[VALUE_WIDTH-1];
        end
        OP_DSTORE: begin
          magnitude <= div_quot;
          count     <= count + 1'b1;
        end
        OP_ZERO: begin
          count <= CNT_W'(1);
        end
        OP_RDADDR: begin
          count <= count_dec;
        end
        default: begin
        end
      endcase
    end
  end

  // Input capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_q <= value;
      radix_q <= radix;
    end
  end

  // Digit store write and registered read.
  always_ff @(posedge clk) begin
    if (cw.op == OP_DSTORE) begin
      digit_store[count[ADDR_W-1:0]] <= div_rem;
    end else if (cw.op == OP_ZERO) begin
      digit_store[{ADDR_W{1'b0}}] <= '0;
    end
    if (cw.op == OP_RDADDR) begin
      rdata <= digit_store[count_dec[ADDR_W-1:0]];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      case (cw.op)
        OP_MINUS: begin
          character <= CHAR_MINUS;
          last      <= 1'b0;
          status    <= STATUS_OK;
        end
        OP_EMITD: begin
          character <= digit_char(rdata);
          last      <= (count == '0);
          status    <= STATUS_OK;
        end
        default: begin
          character <= CHAR_NONE;
          last      <= 1'b1;
          status    <= radix_bad ? STATUS_BAD_RADIX : STATUS_NEG_RADIX;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // A new input is never taken while the divider is still working.
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !div_busy)
    else $error("input taken while divider busy");

  // An error result is always a lone, final, empty character.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != STATUS_OK)) |-> (last && (character == CHAR_NONE)))
    else $error("malformed error result");

  // The divider is only started when idle.
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A held result is not overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(character) && $stable(last) && out_valid))
    else $error("output changed while stalled");
`endif

endmodule
`default_nettype wire
